// ===== design/rfs_pkg.sv =====
// Shared types and constants for the restriction fragment scanner.
// Used by rfs_scan, rfs_rsp_buf and restriction_fragment_scanner; no dependencies.
package rfs_pkg;

   // Default position counter width
   localparam int POS_WIDTH_DEF = 32;

   // Configuration port geometry and register indexes
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MIN_FRAG = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_FRAG = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OUT_MODE = 2'd2;

   // Configuration reset values
   localparam logic [15:0] MIN_FRAG_RST = 16'd40;
   localparam logic [15:0] MAX_FRAG_RST = 16'd220;

   // Output modes
   localparam logic MODE_FRAGMENT = 1'b0;
   localparam logic MODE_ALL_CPG  = 1'b1;

   // Record kinds
   localparam logic KIND_FRAGMENT = 1'b0;
   localparam logic KIND_CPG      = 1'b1;

   // Input transaction
   typedef struct packed {
      logic [7:0] residue;
      logic       seq_end;
   } req_type;

   // Result transaction
   typedef struct packed {
      logic        kind;
      logic [31:0] start_pos;
      logic [31:0] stop_pos;
      logic [31:0] cpg_count;
      logic        last;
   } rsp_type;

   // Configuration registers
   typedef struct packed {
      logic [15:0] min_frag;
      logic [15:0] max_frag;
      logic        out_mode;
   } cfg_type;

   // Records produced by one scanned residue (up to two)
   typedef struct packed {
      logic [1:0] count;
      rsp_type    rec0;
      rsp_type    rec1;
   } scan_out_type;

endpackage

// ===== design/rfs_scan.sv =====
// Per-residue CG / CCGG matcher with position, fragment and CpG state.
// Depends on rfs_pkg; builds the records one residue causes in a single pass.
module rfs_scan #(
   parameter int POS_WIDTH = rfs_pkg::POS_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  rfs_pkg::req_type      item,
   input  rfs_pkg::cfg_type      cfg,
   output rfs_pkg::scan_out_type result
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_C,
      ST_CC,
      ST_CCG
   } match_type;

   typedef enum logic [2:0] {
      CODE_A,
      CODE_C,
      CODE_G,
      CODE_T,
      CODE_BAD
   } base_type;

   localparam logic [POS_WIDTH-1:0] POS_MAX = {POS_WIDTH{1'b1}};
   localparam logic [POS_WIDTH-1:0] POS_ONE = POS_WIDTH'(1);
   localparam logic [POS_WIDTH-1:0] POS_THREE = POS_WIDTH'(3);

   match_type            match_ff, match_in;
   logic [POS_WIDTH-1:0] position_ff, position_in;
   logic [POS_WIDTH-1:0] frag_start_ff, frag_start_in;
   logic [31:0]          cpg_ff, cpg_in;

   logic [7:0]           upper;
   base_type             code;
   match_type            match_next;
   logic                 cg_hit, site_hit;
   logic [POS_WIDTH-1:0] pos, cut, tail_start;
   logic [31:0]          cnt_a, tail_cnt;
   logic                 site_ok, tail_ok;
   rfs_pkg::rsp_type     cpg_rec, site_rec, tail_rec;

   // Length window check; a zero limit disables it
   function automatic logic len_ok(input logic [POS_WIDTH-1:0] start,
                                   input logic [POS_WIDTH-1:0] stop,
                                   input logic [15:0] lo,
                                   input logic [15:0] hi);
      logic [POS_WIDTH:0] len;
      logic               ok;
      len = (stop >= start) ? ({1'b0, stop} - {1'b0, start} + (POS_WIDTH+1)'(1))
                            : '0;
      if (lo != 16'd0 && hi != 16'd0) begin
         ok = (len >= (POS_WIDTH+1)'(lo)) && (len <= (POS_WIDTH+1)'(hi));
      end else begin
         ok = 1'b1;
      end
      return ok;
   endfunction

   // Classify the character, lower case folded, U read as T
   always_comb begin
      upper = (item.residue >= 8'd97 && item.residue <= 8'd122) ?
              item.residue - 8'd32 : item.residue;
      case (upper)
         8'd65:   code = CODE_A;
         8'd67:   code = CODE_C;
         8'd71:   code = CODE_G;
         8'd84,
         8'd85:   code = CODE_T;
         default: code = CODE_BAD;
      endcase
   end

   // Matcher transition
   always_comb begin
      match_next = ST_IDLE;
      cg_hit     = 1'b0;
      site_hit   = 1'b0;
      unique case (code)
         CODE_C: begin
            match_next = (match_ff == ST_C || match_ff == ST_CC) ? ST_CC : ST_C;
         end
         CODE_G: begin
            unique case (match_ff)
               ST_C:    cg_hit = 1'b1;
               ST_CC: begin
                  cg_hit     = 1'b1;
                  match_next = ST_CCG;
               end
               ST_CCG:  site_hit = 1'b1;
               default: ;
            endcase
         end
         CODE_BAD: match_next = match_ff;
         default:  match_next = ST_IDLE;
      endcase
   end

   // Positions and counts
   always_comb begin
      pos        = (position_ff != POS_MAX) ? position_ff + POS_ONE : POS_MAX;
      cut        = pos - POS_THREE;
      cnt_a      = (cg_hit && cpg_ff != 32'hFFFF_FFFF) ? cpg_ff + 32'd1 : cpg_ff;
      tail_start = site_hit ? cut + POS_ONE : frag_start_ff;
      tail_cnt   = site_hit ? 32'd1 : cnt_a;
      site_ok    = site_hit && len_ok(frag_start_ff, cut, cfg.min_frag, cfg.max_frag);
      tail_ok    = item.seq_end && len_ok(tail_start, pos, cfg.min_frag, cfg.max_frag);
   end

   // Record candidates
   always_comb begin
      cpg_rec.kind      = rfs_pkg::KIND_CPG;
      cpg_rec.start_pos = 32'(pos - POS_ONE);
      cpg_rec.stop_pos  = 32'(pos - POS_ONE);
      cpg_rec.cpg_count = 32'd0;
      cpg_rec.last      = 1'b1;

      site_rec.kind      = rfs_pkg::KIND_FRAGMENT;
      site_rec.start_pos = 32'(frag_start_ff);
      site_rec.stop_pos  = 32'(cut);
      site_rec.cpg_count = cnt_a;
      site_rec.last      = 1'b0;

      tail_rec.kind      = rfs_pkg::KIND_FRAGMENT;
      tail_rec.start_pos = 32'(tail_start);
      tail_rec.stop_pos  = 32'(pos);
      tail_rec.cpg_count = tail_cnt;
      tail_rec.last      = 1'b1;
   end

   // Result selection
   always_comb begin
      result.count = 2'd0;
      result.rec0  = tail_rec;
      result.rec1  = tail_rec;
      if (cfg.out_mode == rfs_pkg::MODE_ALL_CPG) begin
         result.rec0  = cpg_rec;
         result.count = {1'b0, cg_hit};
      end else if (site_ok) begin
         result.rec0 = site_rec;
         if (tail_ok) begin
            result.count = 2'd2;
         end else begin
            result.rec0.last = 1'b1;
            result.count     = 2'd1;
         end
      end else if (tail_ok) begin
         result.count = 2'd1;
      end
   end

   // Next state
   always_comb begin
      match_in      = match_ff;
      position_in   = position_ff;
      frag_start_in = frag_start_ff;
      cpg_in        = cpg_ff;
      if (fire) begin
         if (item.seq_end) begin
            match_in      = ST_IDLE;
            position_in   = '0;
            frag_start_in = POS_ONE;
            cpg_in        = 32'd0;
         end else begin
            match_in      = match_next;
            position_in   = pos;
            frag_start_in = tail_start;
            cpg_in        = tail_cnt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff      <= ST_IDLE;
         position_ff   <= '0;
         frag_start_ff <= POS_ONE;
         cpg_ff        <= 32'd0;
      end else begin
         match_ff      <= match_in;
         position_ff   <= position_in;
         frag_start_ff <= frag_start_in;
         cpg_ff        <= cpg_in;
      end
   end

   // A fragment never starts at position zero
   a_start_nonzero: assert property (@(posedge clock) disable iff (reset)
      frag_start_ff != '0)
      else $error("fragment start reached zero");

endmodule

// ===== design/rfs_rsp_buf.sv =====
// Two-record result register that drains one record per transaction.
// Depends on rfs_pkg; loaded from rfs_scan, drives the result channel.
module rfs_rsp_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  rfs_pkg::scan_out_type scan,
   output logic                  space,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rfs_pkg::rsp_type      rsp_data
);

   logic [1:0]       cnt_ff, cnt_in;
   rfs_pkg::rsp_type rec0_ff, rec0_in;
   rfs_pkg::rsp_type rec1_ff;
   logic             pop;

   assign rsp_valid = cnt_ff != 2'd0;
   assign rsp_data  = rec0_ff;
   assign pop       = rsp_valid && !rsp_stall;
   assign space     = (cnt_ff == 2'd0) || (cnt_ff == 2'd1 && pop);

   // Fill from the scanner or shift the second record forward
   always_comb begin
      cnt_in  = cnt_ff;
      rec0_in = rec0_ff;
      if (load) begin
         cnt_in  = scan.count;
         rec0_in = scan.rec0;
      end else if (pop) begin
         cnt_in  = cnt_ff - 2'd1;
         rec0_in = rec1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rec0_ff <= rec0_in;
      if (load) begin
         rec1_ff <= scan.rec1;
      end
   end

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("result count out of range");

   a_load_space: assert property (@(posedge clock) disable iff (reset)
      load |-> (cnt_ff == 2'd0 || (cnt_ff == 2'd1 && pop)))
      else $error("load while result register occupied");

   a_pair_drain: assert property (@(posedge clock) disable iff (reset)
      (pop && cnt_ff == 2'd2) |=> rsp_valid)
      else $error("second record lost");

endmodule

// ===== design/restriction_fragment_scanner.sv =====
// MspI fragment scanner: one residue per transaction, up to two results each.
// Path: input register, scan logic, then the result register to the output.
// Throughput: 1 residue per cycle unless stalled; a residue with two results
// holds the result register, and stalls input, until both have drained.
// Reset (synchronous): scan state and config return to defaults, buffers empty.
module restriction_fragment_scanner #(
   parameter int POS_WIDTH = rfs_pkg::POS_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  rfs_pkg::req_type                     req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output rfs_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_write,
   input  logic [rfs_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [rfs_pkg::CSR_DATA_WIDTH-1:0]   csr_data
);

   logic                  in_valid_ff, in_valid_in;
   rfs_pkg::req_type      in_data_ff;
   rfs_pkg::cfg_type      cfg_ff;
   rfs_pkg::scan_out_type scan;
   logic                  space, scan_fire, buf_load, req_take;

   // Scan the held residue when its records fit
   assign scan_fire = in_valid_ff && (scan.count == 2'd0 || space);
   assign buf_load  = scan_fire && scan.count != 2'd0;
   assign req_stall = in_valid_ff && !scan_fire;
   assign req_take  = req_valid && !req_stall;

   // Input register
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (scan_fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_frag <= rfs_pkg::MIN_FRAG_RST;
         cfg_ff.max_frag <= rfs_pkg::MAX_FRAG_RST;
         cfg_ff.out_mode <= rfs_pkg::MODE_FRAGMENT;
      end else if (csr_write) begin
         unique case (csr_index)
            rfs_pkg::CSR_MIN_FRAG: cfg_ff.min_frag <= csr_data;
            rfs_pkg::CSR_MAX_FRAG: cfg_ff.max_frag <= csr_data;
            rfs_pkg::CSR_OUT_MODE: cfg_ff.out_mode <= csr_data[0];
            default: ;
         endcase
      end
   end

   rfs_scan #(
      .POS_WIDTH (POS_WIDTH)
   ) u_scan (
      .clock  (clock),
      .reset  (reset),
      .fire   (scan_fire),
      .item   (in_data_ff),
      .cfg    (cfg_ff),
      .result (scan)
   );

   rfs_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .load      (buf_load),
      .scan      (scan),
      .space     (space),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
